### rtl/core/dbcs_pkg.sv
`timescale 1ns / 1ps
// dbcs_pkg: function codes, result and table entry types, and constants for the
// code page decoder. No dependencies.
package dbcs_pkg;

    typedef enum logic [2:0] {
        FN_DATA        = 3'd0,
        FN_EOS         = 3'd1,
        FN_LOAD_SINGLE = 3'd2,
        FN_LOAD_LEAD   = 3'd3,
        FN_LOAD_PAIR   = 3'd4
    } t_func;

    localparam logic [15:0] REPL_CHAR   = 16'hFFFD;
    localparam int          TABLE_SIZE  = 256;
    localparam int          FIFO_DEPTH  = 8;
    localparam int          RES_MAX     = 2;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        lossy;
        logic        last;
    } t_res;

    typedef struct packed {
        logic       mark;
        logic [6:0] row;
    } t_lead_entry;

endpackage

### rtl/core/dbcs_codepage_decoder.sv
`timescale 1ns / 1ps
// dbcs_codepage_decoder: byte stream to UTF-16 code unit decoder with its
// single, lead and pair tables in on-chip memories. Depends on dbcs_pkg.
//
//  channel | direction | handshake                      | beat
//  --------+-----------+--------------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_ready        | func, byte, row, flag, entry
//  out     | output    | o_out_valid / i_out_ready      | code unit, lossy, last
//  cfg     | input     | i_cfg_we                       | double byte mode
//
// One input beat per cycle. A beat reads all three tables in the cycle it is
// accepted and resolves in the cycle after, pushing up to two results into an
// eight-entry output queue; results leave one per cycle while i_out_ready is high.
// Input stalls only when the queue could not take the worst case of the beats
// in flight. Synchronous active-low reset clears the held lead and the queue;
// the tables are not cleared and need no clearing pass.
module dbcs_codepage_decoder #(
    parameter int ROW_COUNT = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_byte_value,
    input  logic [6:0]  i_row_index,
    input  logic        i_lead_flag,
    input  logic [15:0] i_entry_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_code_unit,
    output logic        o_lossy,
    output logic        o_last
);

    localparam int ROW_W      = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int PAIR_DEPTH = ROW_COUNT * dbcs_pkg::TABLE_SIZE;
    localparam int PAIR_AW    = ROW_W + 8;
    localparam int PTR_W      = $clog2(dbcs_pkg::FIFO_DEPTH);
    localparam int CNT_W      = $clog2(dbcs_pkg::FIFO_DEPTH + 1);
    localparam logic [8:0] ROW_LIMIT = 9'(ROW_COUNT);
    localparam logic [CNT_W:0] ROOM_LIMIT =
        (CNT_W + 1)'(dbcs_pkg::FIFO_DEPTH - dbcs_pkg::RES_MAX);

    // table memories
    logic [15:0]           r_single_mem [dbcs_pkg::TABLE_SIZE];
    dbcs_pkg::t_lead_entry r_lead_mem   [dbcs_pkg::TABLE_SIZE];
    logic [15:0]           r_pair_mem   [PAIR_DEPTH];

    logic                  r_dbm;
    logic                  r_pending, n_pending;
    logic [6:0]            r_held_row, n_held_row;
    logic [7:0]            r_held_byte, n_held_byte;

    logic                  r_s1_valid;
    logic [2:0]            r_s1_func;
    logic [7:0]            r_s1_byte;
    logic [6:0]            r_s1_row;
    logic [15:0]           r_single_rd;
    dbcs_pkg::t_lead_entry r_lead_rd;
    logic [15:0]           r_pair_rd;

    dbcs_pkg::t_res        r_fifo [dbcs_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0]      r_wptr, r_rptr;
    logic [CNT_W-1:0]      r_count;

    logic                  in_acc, out_acc;
    logic [8:0]            row_ext, wr_row_ext;
    logic [PAIR_AW-1:0]    pair_raddr, pair_waddr;
    logic                  pair_wr_ok, held_in_range, pair_def, lone_lead;
    dbcs_pkg::t_res        res0, res1;
    logic [1:0]            n_push;

    assign in_acc  = i_in_valid & o_in_ready;
    assign out_acc = o_out_valid & i_out_ready;

    assign o_in_ready = ({1'b0, r_count} + (r_s1_valid ? (CNT_W + 1)'(dbcs_pkg::RES_MAX)
                                                       : '0)) <= ROOM_LIMIT;

    // held lead as seen by the beat now entering; a lead load in flight may
    // rewrite the row of the held byte
    always_comb begin
        n_held_row  = r_held_row;
        n_held_byte = r_held_byte;
        if (r_s1_valid && r_s1_func == dbcs_pkg::FN_DATA) begin
            n_held_row  = r_lead_rd.row;
            n_held_byte = r_s1_byte;
        end else if (r_s1_valid && r_s1_func == dbcs_pkg::FN_LOAD_LEAD
                     && r_s1_byte == r_held_byte) begin
            n_held_row = r_s1_row;
        end
    end

    assign row_ext    = {2'b00, n_held_row};
    assign wr_row_ext = {2'b00, i_row_index};
    assign pair_raddr = {row_ext[ROW_W-1:0], i_byte_value};
    assign pair_waddr = {wr_row_ext[ROW_W-1:0], i_byte_value};
    assign pair_wr_ok = wr_row_ext < ROW_LIMIT;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (i_func == dbcs_pkg::FN_LOAD_SINGLE) begin
                r_single_mem[i_byte_value] <= i_entry_value;
            end
            r_single_rd <= r_single_mem[i_byte_value];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (i_func == dbcs_pkg::FN_LOAD_LEAD) begin
                r_lead_mem[i_byte_value] <= '{mark: i_lead_flag, row: i_row_index};
            end
            r_lead_rd <= r_lead_mem[i_byte_value];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            if (i_func == dbcs_pkg::FN_LOAD_PAIR && pair_wr_ok) begin
                r_pair_mem[pair_waddr] <= i_entry_value;
            end
            r_pair_rd <= r_pair_mem[pair_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_func   <= i_func;
        r_s1_byte   <= i_byte_value;
        r_s1_row    <= i_row_index;
        r_held_row  <= n_held_row;
        r_held_byte <= n_held_byte;
        if (!i_rst_n) begin
            r_dbm      <= 1'b0;
            r_pending  <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_dbm <= i_cfg_wdata;
            end
            r_pending  <= n_pending;
            r_s1_valid <= in_acc;
        end
    end

    // resolve stage
    assign held_in_range = {2'b00, r_held_row} < ROW_LIMIT;
    assign pair_def      = r_pending && held_in_range && r_pair_rd != dbcs_pkg::REPL_CHAR;
    assign lone_lead     = r_dbm && r_lead_rd.mark;

    always_comb begin
        n_pending = r_pending;
        res0      = '0;
        res1      = '0;
        n_push    = 2'd0;
        if (r_s1_valid) begin
            unique case (r_s1_func)
                dbcs_pkg::FN_DATA: begin
                    if (pair_def) begin
                        res0      = '{code_unit: r_pair_rd, lossy: 1'b0, last: 1'b1};
                        n_push    = 2'd1;
                        n_pending = 1'b0;
                    end else if (r_pending) begin
                        res0 = '{code_unit: dbcs_pkg::REPL_CHAR, lossy: 1'b1, last: 1'b0};
                        if (lone_lead) begin
                            res0.last = 1'b1;
                            n_push    = 2'd1;
                            n_pending = 1'b1;
                        end else begin
                            res1 = '{code_unit: r_single_rd,
                                     lossy: r_single_rd == dbcs_pkg::REPL_CHAR,
                                     last: 1'b1};
                            n_push    = 2'd2;
                            n_pending = 1'b0;
                        end
                    end else if (lone_lead) begin
                        n_pending = 1'b1;
                    end else begin
                        res0 = '{code_unit: r_single_rd,
                                 lossy: r_single_rd == dbcs_pkg::REPL_CHAR,
                                 last: 1'b1};
                        n_push = 2'd1;
                    end
                end
                dbcs_pkg::FN_EOS: begin
                    if (r_pending) begin
                        res0      = '{code_unit: dbcs_pkg::REPL_CHAR, lossy: 1'b1, last: 1'b1};
                        n_push    = 2'd1;
                        n_pending = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output queue
    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_fifo[r_wptr] <= res0;
        end
        if (n_push == 2'd2) begin
            r_fifo[r_wptr + PTR_W'(1)] <= res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(n_push);
            r_rptr  <= r_rptr + PTR_W'(out_acc);
            r_count <= r_count + CNT_W'(n_push) - CNT_W'(out_acc);
        end
    end

    assign o_out_valid = r_count != '0;
    assign o_code_unit = r_fifo[r_rptr].code_unit;
    assign o_lossy     = r_fifo[r_rptr].lossy;
    assign o_last      = r_fifo[r_rptr].last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(dbcs_pkg::FIFO_DEPTH))
        else $error("output queue overflow");

    a_eos_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_func == dbcs_pkg::FN_EOS) |=> !r_pending)
        else $error("held lead survived end of stream");

    a_pair_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_func == dbcs_pkg::FN_DATA && pair_def) |=> !r_pending)
        else $error("held lead survived a defined pair");

    a_lossy_repl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_lossy == (o_code_unit == dbcs_pkg::REPL_CHAR)))
        else $error("lossy flag disagrees with code unit");

endmodule
